// ----- design/wesh_pkg.sv -----
`default_nettype none
package wesh_pkg;

  localparam int MaxEvents  = 8;
  localparam int NoneBin    = MaxEvents;
  localparam int NumBins    = MaxEvents + 1;
  localparam int CountWidth = 32;
  localparam int OutCountW  = 32;
  localparam int IdxW       = 4;
  localparam int RandW      = 15;
  localparam int WeightW    = 16;
  localparam int SumW       = WeightW + $clog2(MaxEvents);
  localparam int RegW       = 64;
  localparam int AddrW      = 5;
  localparam int RegSelW    = 2;

  localparam logic [RegSelW-1:0] RegWeightsLow  = 2'd0;
  localparam logic [RegSelW-1:0] RegWeightsHigh = 2'd1;
  localparam logic [RegSelW-1:0] RegEventCount  = 2'd2;

  typedef logic [CountWidth-1:0] cnt_t;
  typedef logic [IdxW-1:0]       idx_t;

  typedef struct packed {
    logic [IdxW-1:0]                     n;
    logic [MaxEvents-1:0][SumW-1:0]      prefix;
  } cfg_t;

  typedef struct packed {
    idx_t most_idx;
    cnt_t most_cnt;
    idx_t least_idx;
    cnt_t least_cnt;
  } rank_t;

endpackage
`default_nettype wire

// ----- design/wesh_cfg.sv -----
`default_nettype none
module wesh_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wesh_pkg::AddrW-1:0]  paddr,
  input  wire logic [wesh_pkg::RegW-1:0]   pwdata,
  output logic      [wesh_pkg::RegW-1:0]   prdata,
  output wesh_pkg::cfg_t                   cfg_o
);

  logic [wesh_pkg::RegW-1:0] weights_low_q, weights_high_q;
  logic [3:0] event_count_q;
  logic [wesh_pkg::MaxEvents-1:0][wesh_pkg::SumW-1:0] prefix_q, prefix_d;
  logic [wesh_pkg::RegSelW-1:0] sel;
  logic wr;

  assign sel = paddr[wesh_pkg::AddrW-1:3];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_low_q  <= '0;
      weights_high_q <= '0;
      event_count_q  <= 4'd1;
      prefix_q       <= '0;
    end else begin
      prefix_q <= prefix_d;
      if (wr) begin
        case (sel)
          wesh_pkg::RegWeightsLow:  weights_low_q  <= pwdata;
          wesh_pkg::RegWeightsHigh: weights_high_q <= pwdata;
          wesh_pkg::RegEventCount:  event_count_q  <= pwdata[3:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    logic [wesh_pkg::SumW-1:0] acc;
    logic [2*wesh_pkg::RegW-1:0] all_w;
    acc = '0;
    all_w = {weights_high_q, weights_low_q};
    prefix_d = '0;
    for (int i = 0; i < wesh_pkg::MaxEvents; i++) begin
      acc = acc + wesh_pkg::SumW'(all_w[i*wesh_pkg::WeightW +: wesh_pkg::WeightW]);
      prefix_d[i] = acc;
    end
  end

  always_comb begin
    case (sel)
      wesh_pkg::RegWeightsLow:  prdata = weights_low_q;
      wesh_pkg::RegWeightsHigh: prdata = weights_high_q;
      wesh_pkg::RegEventCount:  prdata = wesh_pkg::RegW'(event_count_q);
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o.prefix = prefix_q;
  assign cfg_o.n = (event_count_q > 4'(wesh_pkg::MaxEvents)) ?
                   wesh_pkg::IdxW'(wesh_pkg::MaxEvents) : event_count_q;

endmodule
`default_nettype wire

// ----- design/wesh_sel.sv -----
`default_nettype none
module wesh_sel (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire wesh_pkg::cfg_t                       cfg_i,
  input  wire logic                                 in_valid_i,
  input  wire logic [wesh_pkg::RandW-1:0]           random_value_i,
  input  wire logic                                 adv1_i,
  input  wire logic                                 adv2_i,
  output logic                                      v1_o,
  output logic                                      v2_o,
  output wesh_pkg::idx_t                            pick_o,
  output wesh_pkg::cnt_t                            pick_cnt_o,
  output logic [wesh_pkg::NumBins-1:0][wesh_pkg::CountWidth-1:0] counters_o
);

  logic v1_q, v2_q;
  logic [wesh_pkg::RandW-1:0] r1_q;
  wesh_pkg::idx_t pick_q, pick_d;
  wesh_pkg::cnt_t cnt2_q, new_cnt;
  logic [wesh_pkg::NumBins-1:0][wesh_pkg::CountWidth-1:0] counters_q;

  always_comb begin
    logic found;
    found  = 1'b0;
    pick_d = wesh_pkg::IdxW'(wesh_pkg::NoneBin);
    for (int i = 0; i < wesh_pkg::MaxEvents; i++) begin
      if (!found && (wesh_pkg::IdxW'(i) < cfg_i.n) &&
          (cfg_i.prefix[i] >= wesh_pkg::SumW'(r1_q))) begin
        found  = 1'b1;
        pick_d = wesh_pkg::IdxW'(i);
      end
    end
  end

  always_comb begin
    wesh_pkg::cnt_t cur;
    cur = counters_q[pick_d];
    new_cnt = (cur == '1) ? cur : cur + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      counters_q <= '0;
    end else begin
      if (adv1_i) v1_q <= in_valid_i;
      if (adv2_i) begin
        v2_q <= v1_q;
        if (v1_q) counters_q[pick_d] <= new_cnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1_i && in_valid_i) r1_q <= random_value_i;
    if (adv2_i && v1_q) begin
      pick_q <= pick_d;
      cnt2_q <= new_cnt;
    end
  end

  assign v1_o       = v1_q;
  assign v2_o       = v2_q;
  assign pick_o     = pick_q;
  assign pick_cnt_o = cnt2_q;
  assign counters_o = counters_q;

endmodule
`default_nettype wire

// ----- design/wesh_rank.sv -----
`default_nettype none
module wesh_rank (
  input  wire wesh_pkg::cfg_t                                    cfg_i,
  input  wire logic [wesh_pkg::NumBins-1:0][wesh_pkg::CountWidth-1:0] counters_i,
  output wesh_pkg::rank_t                                        rank_o
);

  localparam int Leaves = 16;
  localparam int Levels = 4;

  logic           mx_v [Levels+1][Leaves];
  wesh_pkg::idx_t mx_i [Levels+1][Leaves];
  wesh_pkg::cnt_t mx_c [Levels+1][Leaves];
  logic           mn_v [Levels+1][Leaves];
  wesh_pkg::idx_t mn_i [Levels+1][Leaves];
  wesh_pkg::cnt_t mn_c [Levels+1][Leaves];

  always_comb begin
    for (int l = 0; l <= Levels; l++) begin
      for (int j = 0; j < Leaves; j++) begin
        mx_v[l][j] = 1'b0; mx_i[l][j] = '0; mx_c[l][j] = '0;
        mn_v[l][j] = 1'b0; mn_i[l][j] = '0; mn_c[l][j] = '0;
      end
    end
    for (int j = 0; j < wesh_pkg::NumBins; j++) begin
      if (j == wesh_pkg::NoneBin) mx_v[0][j] = (counters_i[j] != '0);
      else                        mx_v[0][j] = (wesh_pkg::IdxW'(j) < cfg_i.n);
      if (mx_v[0][j]) begin
        mx_i[0][j] = wesh_pkg::IdxW'(j);
        mx_c[0][j] = counters_i[j];
      end
      mn_v[0][j] = mx_v[0][j];
      mn_i[0][j] = mx_i[0][j];
      mn_c[0][j] = mx_c[0][j];
    end
    for (int l = 0; l < Levels; l++) begin
      for (int j = 0; j < Leaves / 2; j++) begin
        if (j < (Leaves >> (l + 1))) begin
          if (!mx_v[l][2*j] ||
              (mx_v[l][2*j+1] && (mx_c[l][2*j+1] > mx_c[l][2*j]))) begin
            mx_v[l+1][j] = mx_v[l][2*j+1];
            mx_i[l+1][j] = mx_i[l][2*j+1];
            mx_c[l+1][j] = mx_c[l][2*j+1];
          end else begin
            mx_v[l+1][j] = mx_v[l][2*j];
            mx_i[l+1][j] = mx_i[l][2*j];
            mx_c[l+1][j] = mx_c[l][2*j];
          end
          if (!mn_v[l][2*j] ||
              (mn_v[l][2*j+1] && (mn_c[l][2*j+1] < mn_c[l][2*j]))) begin
            mn_v[l+1][j] = mn_v[l][2*j+1];
            mn_i[l+1][j] = mn_i[l][2*j+1];
            mn_c[l+1][j] = mn_c[l][2*j+1];
          end else begin
            mn_v[l+1][j] = mn_v[l][2*j];
            mn_i[l+1][j] = mn_i[l][2*j];
            mn_c[l+1][j] = mn_c[l][2*j];
          end
        end
      end
    end
  end

  assign rank_o.most_idx  = mx_v[Levels][0] ? mx_i[Levels][0] : '0;
  assign rank_o.most_cnt  = mx_v[Levels][0] ? mx_c[Levels][0] : '0;
  assign rank_o.least_idx = mn_v[Levels][0] ? mn_i[Levels][0] : '0;
  assign rank_o.least_cnt = mn_v[Levels][0] ? mn_c[Levels][0] : '0;

endmodule
`default_nettype wire

// ----- design/weighted_event_sampler_histogram.sv -----
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    random_value_i
// out       output     out_valid_o / out_ready_i  chosen_*, most_*, least_*
// cfg       input      psel/penable/pwrite        paddr, pwdata, prdata, pready
//
// One item per cycle sustained while out_ready_i is held high; an accepted item
// passes the input register, pick and counter update, and result register in turn.
// Reset clears the nine outcome counters, valid flags and config registers at once; no sweep.
// A stalled result holds the result register; up to two more items are still
// taken into the input and pick stages before in_ready_o drops.
`default_nettype none
module weighted_event_sampler_histogram (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [wesh_pkg::RandW-1:0]          random_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic      [wesh_pkg::IdxW-1:0]           chosen_index_o,
  output logic      [wesh_pkg::OutCountW-1:0]      chosen_count_o,
  output logic      [wesh_pkg::IdxW-1:0]           most_index_o,
  output logic      [wesh_pkg::OutCountW-1:0]      most_count_o,
  output logic      [wesh_pkg::IdxW-1:0]           least_index_o,
  output logic      [wesh_pkg::OutCountW-1:0]      least_count_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [wesh_pkg::AddrW-1:0]          paddr,
  input  wire logic [wesh_pkg::RegW-1:0]           pwdata,
  output logic      [wesh_pkg::RegW-1:0]           prdata,
  output logic                                     pready
);

  wesh_pkg::cfg_t  cfg;
  wesh_pkg::rank_t rank;
  wesh_pkg::idx_t  pick;
  wesh_pkg::cnt_t  pick_cnt;
  logic [wesh_pkg::NumBins-1:0][wesh_pkg::CountWidth-1:0] counters;
  logic v1, v2, adv1, adv2, adv_out;
  logic out_v_q;

  assign pready  = 1'b1;
  assign adv_out = !out_v_q || out_ready_i;
  assign adv2    = !v2 || adv_out;
  assign adv1    = !v1 || adv2;
  assign in_ready_o = adv1;

  wesh_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  wesh_sel u_sel (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .random_value_i (random_value_i),
    .adv1_i         (adv1),
    .adv2_i         (adv2),
    .v1_o           (v1),
    .v2_o           (v2),
    .pick_o         (pick),
    .pick_cnt_o     (pick_cnt),
    .counters_o     (counters)
  );

  wesh_rank u_rank (
    .cfg_i      (cfg),
    .counters_i (counters),
    .rank_o     (rank)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv_out) begin
      out_v_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && v2) begin
      chosen_index_o <= pick;
      chosen_count_o <= wesh_pkg::OutCountW'(pick_cnt);
      most_index_o   <= rank.most_idx;
      most_count_o   <= wesh_pkg::OutCountW'(rank.most_cnt);
      least_index_o  <= rank.least_idx;
      least_count_o  <= wesh_pkg::OutCountW'(rank.least_cnt);
    end
  end

  assign out_valid_o = out_v_q;

endmodule
`default_nettype wire
